// ===== hdl/sbf_pkg.sv =====
package sbf_pkg;

    localparam int DEPTH_BITS   = 16;
    localparam int LENGTH_BITS  = 16;
    localparam int LEN_OUT_BITS = 16;

    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX  = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN  = {1'b1, {(DEPTH_BITS-1){1'b0}}};
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_ZERO = '0;
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_ONE  = DEPTH_BITS'(1);
    localparam logic [LENGTH_BITS-1:0]       COUNT_MAX  = '1;
    localparam logic [31:0]                  LEN_OUT_MAX = 32'h0000_FFFF;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef enum logic [3:0] {
        MODE_NORMAL,
        MODE_COMMENT,
        MODE_STRING,
        MODE_HASH,
        MODE_BLOCK,
        MODE_BRACE,
        MODE_CLOSED
    } mode_t;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_BEFORE,
        RES_WITH
    } res_t;

    typedef struct packed {
        mode_t                         mode;
        logic signed [DEPTH_BITS-1:0]  depth;
        logic                          seen;
        logic                          sep;
        logic                          qp;
        logic [LENGTH_BITS-1:0]        count;
    } scan_state_t;

    typedef struct packed {
        scan_state_t st;
        res_t        res;
    } scan_ret_t;

    typedef struct packed {
        logic                    valid;
        logic                    kind;
        logic [LEN_OUT_BITS-1:0] length;
    } result_t;

    localparam scan_state_t RESET_STATE = '{
        mode:  MODE_NORMAL,
        depth: DEPTH_ZERO,
        seen:  1'b0,
        sep:   1'b1,
        qp:    1'b0,
        count: '0
    };

    function automatic logic [LENGTH_BITS-1:0] count_inc(input logic [LENGTH_BITS-1:0] n);
        return (n != COUNT_MAX) ? n + LENGTH_BITS'(1) : n;
    endfunction

    function automatic logic [LEN_OUT_BITS-1:0] report_len(input logic [LENGTH_BITS-1:0] n);
        return (32'(n) > LEN_OUT_MAX) ? {LEN_OUT_BITS{1'b1}} : LEN_OUT_BITS'(n);
    endfunction

    function automatic scan_state_t close_literal(input scan_state_t s);
        scan_state_t t;
        t = s;
        if (s.depth == DEPTH_ZERO)
        begin
            t.mode = MODE_CLOSED;
        end
        else
        begin
            t.mode = MODE_NORMAL;
            t.sep  = 1'b1;
            t.seen = 1'b1;
            t.qp   = 1'b0;
        end
        return t;
    endfunction

    function automatic scan_ret_t scan_normal(input scan_state_t s, input logic [7:0] c);
        scan_ret_t r;
        logic      ends;
        r.st  = s;
        r.res = RES_NONE;
        ends  = s.seen && (s.depth == DEPTH_ZERO) && !s.qp;
        case (c)
            CH_SPACE, CH_LF, CH_TAB, CH_CR:
            begin
                if (ends)
                    r.res = RES_BEFORE;
                else
                    r.st.sep = 1'b1;
            end
            CH_SEMI:
            begin
                r.st.mode = MODE_COMMENT;
            end
            CH_DQUOTE:
            begin
                if (ends)
                    r.res = RES_BEFORE;
                else
                    r.st.mode = MODE_STRING;
            end
            CH_HASH:
            begin
                if (ends)
                    r.res = RES_BEFORE;
                else
                    r.st.mode = MODE_HASH;
            end
            CH_LPAREN:
            begin
                if (ends)
                begin
                    r.res = RES_BEFORE;
                end
                else
                begin
                    if (s.depth != DEPTH_MAX)
                        r.st.depth = s.depth + DEPTH_ONE;
                    r.st.seen = 1'b1;
                    r.st.sep  = 1'b1;
                    r.st.qp   = 1'b0;
                end
            end
            CH_RPAREN:
            begin
                if (s.depth != DEPTH_MIN)
                    r.st.depth = s.depth - DEPTH_ONE;
                if (s.seen && (r.st.depth == DEPTH_ZERO))
                    r.res = RES_WITH;
                r.st.seen = 1'b1;
                r.st.sep  = 1'b1;
                r.st.qp   = 1'b0;
            end
            CH_QUOTE:
            begin
                r.st.seen = 1'b1;
                if (s.sep)
                    r.st.qp = 1'b1;
            end
            default:
            begin
                r.st.sep  = 1'b0;
                r.st.qp   = 1'b0;
                r.st.seen = 1'b1;
            end
        endcase
        if (r.res != RES_BEFORE)
            r.st.count = count_inc(s.count);
        return r;
    endfunction

    function automatic scan_ret_t scan_byte(input scan_state_t s, input logic [7:0] c);
        scan_ret_t   r;
        scan_state_t t;
        t     = s;
        r.st  = s;
        r.res = RES_NONE;
        case (s.mode)
            MODE_COMMENT:
            begin
                if (c != CH_LF)
                begin
                    r.st.count = count_inc(s.count);
                end
                else
                begin
                    t.mode = MODE_NORMAL;
                    r = scan_normal(t, c);
                end
            end
            MODE_STRING:
            begin
                t.count = count_inc(s.count);
                r.st = (c == CH_DQUOTE) ? close_literal(t) : t;
            end
            MODE_BLOCK:
            begin
                r.st.count = count_inc(s.count);
                if (c == CH_RBRACE)
                    r.st.mode = MODE_BRACE;
            end
            MODE_BRACE:
            begin
                t.count = count_inc(s.count);
                if (c == CH_HASH)
                    r.st = close_literal(t);
                else
                begin
                    r.st = t;
                    if (c != CH_RBRACE)
                        r.st.mode = MODE_BLOCK;
                end
            end
            MODE_HASH:
            begin
                if (s.sep && (c == CH_LBRACE))
                begin
                    r.st.count = count_inc(s.count);
                    r.st.mode  = MODE_BLOCK;
                end
                else
                begin
                    t.sep  = 1'b0;
                    t.qp   = 1'b0;
                    t.seen = 1'b1;
                    t.mode = MODE_NORMAL;
                    r = scan_normal(t, c);
                end
            end
            default:
            begin
                t.mode = MODE_NORMAL;
                r = scan_normal(t, c);
            end
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/sbf_char_if.sv =====
interface sbf_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink (input valid, input char_in, output ready);
endinterface

// ===== hdl/sbf_bound_if.sv =====
interface sbf_bound_if;
    logic        valid;
    logic        ready;
    logic        boundary_kind;
    logic [15:0] expr_length;

    modport source (output valid, output boundary_kind, output expr_length, input ready);
    modport sink (input valid, input boundary_kind, input expr_length, output ready);
endinterface

// ===== hdl/sexpr_boundary_finder.sv =====
// Scheme top-level expression boundary finder.
// char_ch (sink) takes one source byte per item; bound_ch (source) gives one
// item for each finished expression: boundary_kind 0 when the expression
// ended before the accepted byte, 1 when it ended with that byte (a ')'),
// and expr_length, the bytes since the previous boundary, saturating.
// Throughput: one byte per cycle while no result waits on a stalled bound_ch.
// The scan state is a single register updated by one level of logic per
// byte. A result is valid on bound_ch the cycle after the byte that
// produces it is accepted. A literal closed at depth zero is reported with
// the following byte.
// Stall: the result register holds while bound_ch.ready is low; char_ch.ready
// is low only while a result waits and the sink is not taking it, and then
// rises in the same cycle the sink takes it.
// Reset: rst_n clears the scan state to its start (no expression open, after
// a separator) and empties the result register; no bytes are lost beyond
// those not yet accepted.
module sexpr_boundary_finder (
    input logic        clk,
    input logic        rst_n,
    sbf_char_if.sink   char_ch,
    sbf_bound_if.source bound_ch
);
    import sbf_pkg::*;

    result_t                 scan_res;
    logic                    step;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    out_kind_reg;
    logic [LEN_OUT_BITS-1:0] out_len_reg;

    assign char_ch.ready = !out_valid_reg || bound_ch.ready;
    assign step          = char_ch.valid && char_ch.ready;

    sbf_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .char_in (char_ch.char_in),
        .result  (scan_res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg && !bound_ch.ready;
        if (step)
            out_valid_next = scan_res.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // load the payload only with a new result
    always_ff @(posedge clk)
    begin
        if (step && scan_res.valid)
        begin
            out_kind_reg <= scan_res.kind;
            out_len_reg  <= scan_res.length;
        end
    end

    assign bound_ch.valid         = out_valid_reg;
    assign bound_ch.boundary_kind = out_kind_reg;
    assign bound_ch.expr_length   = out_len_reg;

`ifndef ASSERT_OFF
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (step && scan_res.valid) |=>
            (bound_ch.valid && (bound_ch.boundary_kind == $past(scan_res.kind))))
        else $error("result not loaded into output register");

    a_with_on_rparen: assert property (@(posedge clk) disable iff (!rst_n)
        (step && scan_res.valid && scan_res.kind) |-> (char_ch.char_in == CH_RPAREN))
        else $error("expression closed by a byte other than a close paren");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !bound_ch.ready) |-> !char_ch.ready)
        else $error("input taken while a stalled result waits");

    a_no_result_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !bound_ch.ready) |=> out_valid_reg)
        else $error("stalled result dropped");
`endif

endmodule

// ===== hdl/sbf_scan.sv =====
module sbf_scan (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       char_in,
    output sbf_pkg::result_t result
);
    import sbf_pkg::*;

    scan_state_t state_reg;
    scan_state_t state_next;
    scan_ret_t   cur;
    scan_ret_t   fresh;

    always_comb
    begin
        cur   = scan_byte(state_reg, char_in);
        // a byte that ends the expression before itself, or follows a closed literal, starts the next one
        fresh = scan_byte(RESET_STATE, char_in);
        result.valid  = 1'b0;
        result.kind   = 1'b0;
        result.length = report_len(state_reg.count);
        state_next    = cur.st;
        if ((state_reg.mode == MODE_CLOSED) || (cur.res == RES_BEFORE))
        begin
            result.valid = 1'b1;
            state_next   = fresh.st;
        end
        else if (cur.res == RES_WITH)
        begin
            result.valid  = 1'b1;
            result.kind   = 1'b1;
            result.length = report_len(cur.st.count);
            state_next    = RESET_STATE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= RESET_STATE;
        else if (step)
            state_reg <= state_next;
    end

endmodule

// ===== verif/sexpr_boundary_finder_tb.sv =====
`timescale 1ns / 100ps

module sexpr_boundary_finder_tb;

    import sbf_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_BYTES = 1900;

    typedef struct packed {
        logic        kind;
        logic [15:0] len;
    } bound_t;

    class boundary_tracker;
        mode_t                        mode;
        logic signed [DEPTH_BITS-1:0] depth;
        bit                           seen;
        bit                           sep;
        bit                           qp;
        logic [LENGTH_BITS-1:0]       count;
        bound_t                       pending_bounds[$];
        int                           errors;

        function new();
            clear();
            errors = 0;
        endfunction

        function void clear();
            mode  = MODE_NORMAL;
            depth = DEPTH_ZERO;
            seen  = 1'b0;
            sep   = 1'b1;
            qp    = 1'b0;
            count = '0;
        endfunction

        function void bump();
            if (count != COUNT_MAX)
                count = count + 1'b1;
        endfunction

        function void end_literal();
            if (depth == DEPTH_ZERO)
            begin
                mode = MODE_CLOSED;
            end
            else
            begin
                mode = MODE_NORMAL;
                sep  = 1'b1;
                seen = 1'b1;
                qp   = 1'b0;
            end
        endfunction

        function res_t scan_plain(logic [7:0] c);
            bit ends;
            ends = seen && (depth == DEPTH_ZERO) && !qp;
            case (c)
                CH_SPACE, CH_LF, CH_TAB, CH_CR:
                begin
                    if (ends)
                        return RES_BEFORE;
                    sep = 1'b1;
                end
                CH_SEMI:
                begin
                    mode = MODE_COMMENT;
                end
                CH_DQUOTE:
                begin
                    if (ends)
                        return RES_BEFORE;
                    mode = MODE_STRING;
                end
                CH_HASH:
                begin
                    if (ends)
                        return RES_BEFORE;
                    mode = MODE_HASH;
                end
                CH_LPAREN:
                begin
                    if (ends)
                        return RES_BEFORE;
                    if (depth != DEPTH_MAX)
                        depth = depth + DEPTH_ONE;
                    seen = 1'b1;
                    sep  = 1'b1;
                    qp   = 1'b0;
                end
                CH_RPAREN:
                begin
                    if (depth != DEPTH_MIN)
                        depth = depth - DEPTH_ONE;
                    bump();
                    if (seen && depth == DEPTH_ZERO)
                        return RES_WITH;
                    seen = 1'b1;
                    sep  = 1'b1;
                    qp   = 1'b0;
                    return RES_NONE;
                end
                CH_QUOTE:
                begin
                    seen = 1'b1;
                    if (sep)
                        qp = 1'b1;
                end
                default:
                begin
                    sep  = 1'b0;
                    qp   = 1'b0;
                    seen = 1'b1;
                end
            endcase
            bump();
            return RES_NONE;
        endfunction

        function res_t scan_char(logic [7:0] c);
            case (mode)
                MODE_COMMENT:
                begin
                    if (c != CH_LF)
                    begin
                        bump();
                        return RES_NONE;
                    end
                    mode = MODE_NORMAL;
                end
                MODE_STRING:
                begin
                    bump();
                    if (c == CH_DQUOTE)
                        end_literal();
                    return RES_NONE;
                end
                MODE_BLOCK:
                begin
                    bump();
                    if (c == CH_RBRACE)
                        mode = MODE_BRACE;
                    return RES_NONE;
                end
                MODE_BRACE:
                begin
                    bump();
                    if (c == CH_HASH)
                        end_literal();
                    else if (c != CH_RBRACE)
                        mode = MODE_BLOCK;
                    return RES_NONE;
                end
                MODE_HASH:
                begin
                    // block comment only when the hash followed a separator
                    if (sep && c == CH_LBRACE)
                    begin
                        bump();
                        mode = MODE_BLOCK;
                        return RES_NONE;
                    end
                    sep  = 1'b0;
                    qp   = 1'b0;
                    seen = 1'b1;
                    mode = MODE_NORMAL;
                end
                default:
                begin
                    mode = MODE_NORMAL;
                end
            endcase
            return scan_plain(c);
        endfunction

        function void expect_bound(logic kind, logic [LENGTH_BITS-1:0] n);
            bound_t b;
            b.kind = kind;
            b.len  = (n > LENGTH_BITS'(16'hFFFF)) ? 16'hFFFF : 16'(n);
            pending_bounds.push_back(b);
        endfunction

        function void note_byte(logic [7:0] c);
            logic [LENGTH_BITS-1:0] prior;
            res_t                   r;
            // a literal closed at depth zero ends on the following byte
            if (mode == MODE_CLOSED)
            begin
                expect_bound(1'b0, count);
                clear();
                void'(scan_char(c));
                return;
            end
            prior = count;
            r = scan_char(c);
            if (r == RES_BEFORE)
            begin
                expect_bound(1'b0, prior);
                clear();
                void'(scan_char(c));
            end
            else if (r == RES_WITH)
            begin
                expect_bound(1'b1, count);
                clear();
            end
        endfunction

        function void check_bound(logic kind, logic [15:0] len);
            bound_t b;
            if (pending_bounds.size() == 0)
            begin
                $error("unexpected boundary item: boundary_kind %0d expr_length %0d",
                       kind, len);
                errors++;
                return;
            end
            b = pending_bounds.pop_front();
            if (kind !== b.kind)
            begin
                $error("boundary_kind: expected %0d, got %0d", b.kind, kind);
                errors++;
            end
            if (len !== b.len)
            begin
                $error("expr_length: expected %0d, got %0d", b.len, len);
                errors++;
            end
        endfunction

        function int pending();
            return pending_bounds.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   idle_pct = 27;
    int   sent = 0;

    boundary_tracker sb;

    sbf_char_if  char_if();
    sbf_bound_if bound_if();

    sexpr_boundary_finder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .char_ch  (char_if),
        .bound_ch (bound_if)
    );

    always #6 clk = ~clk;

    task automatic send_byte(input logic [7:0] c);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            char_if.valid <= 1'b0;
            @(posedge clk);
        end
        char_if.valid   <= 1'b1;
        char_if.char_in <= c;
        @(posedge clk);
        while (!char_if.ready)
            @(posedge clk);
        sb.note_byte(c);
        sent++;
    endtask

    task automatic send_run(input logic [7:0] c, input int n);
        repeat (n)
            send_byte(c);
    endtask

    // hold the sender until every boundary item has come back
    task automatic drain();
        char_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] filler();
        string pool;
        pool = "x\\ }#;()'{";
        return pool[$urandom_range(pool.len() - 1)];
    endfunction

    task automatic send_token();
        int pick;
        pick = $urandom_range(19);
        case (pick)
            0, 1, 2, 17, 18, 19:
            begin
                repeat ($urandom_range(1, 4))
                    send_byte(8'h61 + 8'($urandom_range(25)));
            end
            3, 4:
            begin
                send_byte(CH_LPAREN);
            end
            5, 6:
            begin
                send_byte(CH_RPAREN);
            end
            7, 8:
            begin
                case ($urandom_range(3))
                    0: send_byte(CH_SPACE);
                    1: send_byte(CH_LF);
                    2: send_byte(CH_TAB);
                    default: send_byte(CH_CR);
                endcase
            end
            9:
            begin
                send_byte(CH_QUOTE);
            end
            10:
            begin
                send_byte(CH_DQUOTE);
                repeat ($urandom_range(0, 4))
                    send_byte(filler());
                send_byte(CH_DQUOTE);
            end
            11:
            begin
                send_byte(CH_HASH);
                send_byte(CH_LBRACE);
                repeat ($urandom_range(0, 4))
                    send_byte(filler());
                send_byte(CH_RBRACE);
                send_byte(CH_HASH);
            end
            12:
            begin
                send_byte(CH_HASH);
                send_byte(filler());
            end
            13:
            begin
                send_byte(CH_SEMI);
                repeat ($urandom_range(0, 3))
                    send_byte(filler());
                send_byte(CH_LF);
            end
            14:
            begin
                send_byte($urandom_range(1) ? CH_RBRACE : CH_LBRACE);
            end
            default:
            begin
                send_byte(8'($urandom_range(255)));
            end
        endcase
    endtask

    // result side: stall at random, check each accepted item
    initial
    begin
        bound_if.ready = 1'b0;
        forever
        begin
            bound_if.ready <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
            @(posedge clk);
            if (bound_if.valid && bound_if.ready)
                sb.check_bound(bound_if.boundary_kind, bound_if.expr_length);
        end
    end

    initial
    begin
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (char_if.valid && char_if.ready)
                || (bound_if.valid && bound_if.ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("sexpr_boundary_finder_tb: errors");
        $finish;
    end

    initial
    begin
        string directed;
        int    start;
        bit    drained;
        directed = "(a 'b)x \"s\\\"#{}}#;c\n#t'";
        drained  = 1'b0;
        char_if.valid   = 1'b0;
        char_if.char_in = 8'h00;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // lists, quotes, blanks, strings with backslash, block comments, line comments
        for (int i = 0; i < directed.len(); i++)
            send_byte(directed[i]);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_RPAREN);
        drain();

        // nest deep, then close back down to zero
        send_run(CH_LPAREN, 40);
        send_run(CH_RPAREN, 40);
        // go below zero, climb back to zero, end on a blank
        send_run(CH_RPAREN, 3);
        send_run(CH_LPAREN, 3);
        send_byte(CH_SPACE);

        start = sent;
        while (sent - start < RANDOM_BYTES)
        begin
            idle_pct = (sent - start >= 500 && sent - start < 900) ? 0 : 27;
            if (!drained && sent - start >= 1200)
            begin
                drain();
                drained = 1'b1;
            end
            send_token();
        end
        idle_pct = 27;
        drain();
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("sexpr_boundary_finder_tb: clean");
        else
            $display("sexpr_boundary_finder_tb: errors");
        $finish;
    end

endmodule
